// ----- hdl/xte_pkg.sv -----
// Types, constants and round schedule for the two-word block TEA encryptor.
`timescale 1ns / 1ps

package xte_pkg;

  localparam logic [31:0] DELTA = 32'h9e37_79b9;
  // Round count for a two-word block: 6 + 52 / n with n = 2.
  localparam int unsigned ROUNDS = 6 + 52 / 2;
  // Every round updates the first word and then the second.
  localparam int unsigned STAGES = 2 * ROUNDS;

  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_KEY0   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_KEY1   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KEY2   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_KEY3   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_OFFSET = 3'd4;

  typedef struct packed {
    logic [31:0] first_word;
    logic [31:0] second_word;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] cipher_first;
    logic [31:0] cipher_second;
  } out_beat_t;

  // Word pair inside the pipeline. w1 is the word that the next stage updates.
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
  } pair_t;

  // Running sum after round rnd (counted from zero).
  function automatic logic [31:0] round_sum(input int unsigned rnd);
    logic [63:0] prod;
    prod = 64'(DELTA) * 64'(rnd + 1);
    return prod[31:0];
  endfunction

  // Key word index used by pipeline stage stg.
  function automatic logic [1:0] key_sel(input int unsigned stg);
    logic [31:0] s;
    logic [1:0]  e;
    logic [1:0]  p;
    s = round_sum(stg / 2);
    e = s[3:2];
    p = 2'(stg % 2);
    return p ^ e;
  endfunction

endpackage

// ----- hdl/xte_stage.sv -----
// One half round: the word in w1 gains the mix of the other word; the pair is swapped.
`timescale 1ns / 1ps

module xte_stage
  import xte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  pair_t       d_i,
  input  logic [31:0] sum_i,
  input  logic [31:0] key_i,
  output logic        vld_o,
  output pair_t       d_o
);

  logic        vld_r;
  pair_t       d_r;
  pair_t       d_nxt;
  logic [31:0] z;
  logic [31:0] mix_a;
  logic [31:0] mix_b;

  // Both mix operands are the same word at a block length of two.
  assign z     = d_i.w0;
  assign mix_a = ((z >> 5) ^ (z << 2)) + ((z >> 3) ^ (z << 4));
  assign mix_b = (sum_i ^ z) + (key_i ^ z);

  // Swapping puts the freshly updated word in w0, so the next stage mixes it
  // into the other word.
  always_comb begin
    d_nxt.w0 = d_i.w1 + (mix_a ^ mix_b);
    d_nxt.w1 = d_i.w0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// ----- hdl/xxtea_two_word_encrypt.sv -----
// Top level of the pipelined two-word block TEA encryptor.
`timescale 1ns / 1ps

// Encrypts one 64-bit block per beat with 32 rounds of block TEA at block
// length two. The cipher is unrolled into 64 half-round stages, one register
// stage each, so a new block is accepted every cycle unless out_stall holds a
// waiting result. Every result passes through all stages before output. A
// result that waits under out_stall freezes the whole pipeline; in_stall then
// follows out_stall in the same cycle. Each key word is added to the offset
// register and the sum is registered in key_eff_r, so a configuration write
// reaches the stages only through that register.
module xxtea_two_word_encrypt
  import xte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [31:0]       cfg_wdata
);

  logic [31:0]   key_r [4];
  logic [31:0]   offset_r;
  logic [31:0]   key_eff_r [4];
  logic          en;
  logic [STAGES:0] vld;
  pair_t         pipe [STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= '0;
      key_r[1] <= '0;
      key_r[2] <= '0;
      key_r[3] <= '0;
      offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KEY0:   key_r[0] <= cfg_wdata;
        REG_KEY1:   key_r[1] <= cfg_wdata;
        REG_KEY2:   key_r[2] <= cfg_wdata;
        REG_KEY3:   key_r[3] <= cfg_wdata;
        REG_OFFSET: offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      key_eff_r[i] <= key_r[i] + offset_r;
    end
  end

  assign en       = !(vld[STAGES] && out_stall);
  assign in_stall = !en;

  // The first stage updates the first word, so it starts in w1.
  assign vld[0]     = in_valid;
  assign pipe[0].w0 = in_data.second_word;
  assign pipe[0].w1 = in_data.first_word;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic [31:0] SUM = round_sum(s / 2);
    localparam logic [1:0]  KSEL = key_sel(s);

    xte_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld[s]),
      .d_i   (pipe[s]),
      .sum_i (SUM),
      .key_i (key_eff_r[KSEL]),
      .vld_o (vld[s+1]),
      .d_o   (pipe[s+1])
    );
  end

  // After an even number of swaps the order is back to the input order.
  assign out_valid              = vld[STAGES];
  assign out_data.cipher_first  = pipe[STAGES].w1;
  assign out_data.cipher_second = pipe[STAGES].w0;

`ifndef NO_ASSERTIONS
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> vld[STAGES:1] == $past(vld[STAGES:1]))
    else $error("pipeline valid bits moved during a stall");

  a_valid_shifts: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> vld[STAGES:1] == $past(vld[STAGES-1:0]))
    else $error("valid bits did not advance with the pipeline");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld[1])
    else $error("accepted beat did not enter the first stage");

  a_key_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> key_eff_r[0] == $past(key_r[0] + offset_r))
    else $error("effective key word does not follow key plus offset");
`endif

endmodule
